FILE: sv/vsc_pkg.sv
// ============================================================================
// vsc_pkg - shared types and constants for the sync-checking pixel capture
// Item layouts, timing register codes and reset values, channel scaling.
// ============================================================================
package vsc_pkg;

    localparam int CNT_W   = 12;   // column and line counters
    localparam int POS_W   = 11;   // captured pixel position
    localparam int SAMP_W  = 4;    // raw color sample
    localparam int CHAN_W  = 8;    // scaled color channel
    localparam int LEN8_W  = 8;    // porch and sync lengths
    localparam int LEN11_W = 11;   // active lengths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LEN11_W;

    localparam int DEF_RED_BITS   = 4;
    localparam int DEF_GREEN_BITS = 4;
    localparam int DEF_BLUE_BITS  = 4;

    localparam logic [LEN8_W-1:0]  RST_HSYNC_LEN   = 8'd96;
    localparam logic [LEN8_W-1:0]  RST_HBACK_LEN   = 8'd48;
    localparam logic [LEN11_W-1:0] RST_HACTIVE_LEN = 11'd640;
    localparam logic [LEN8_W-1:0]  RST_HFRONT_LEN  = 8'd16;
    localparam logic [LEN8_W-1:0]  RST_VSYNC_LEN   = 8'd2;
    localparam logic [LEN8_W-1:0]  RST_VBACK_LEN   = 8'd33;
    localparam logic [LEN11_W-1:0] RST_VACTIVE_LEN = 11'd480;
    localparam logic [LEN8_W-1:0]  RST_VFRONT_LEN  = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HSYNC_LEN   = 3'd0,
        CFG_HBACK_LEN   = 3'd1,
        CFG_HACTIVE_LEN = 3'd2,
        CFG_HFRONT_LEN  = 3'd3,
        CFG_VSYNC_LEN   = 3'd4,
        CFG_VBACK_LEN   = 3'd5,
        CFG_VACTIVE_LEN = 3'd6,
        CFG_VFRONT_LEN  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [LEN8_W-1:0]  hsync_len;
        logic [LEN8_W-1:0]  hback_len;
        logic [LEN11_W-1:0] hactive_len;
        logic [LEN8_W-1:0]  hfront_len;
        logic [LEN8_W-1:0]  vsync_len;
        logic [LEN8_W-1:0]  vback_len;
        logic [LEN11_W-1:0] vactive_len;
        logic [LEN8_W-1:0]  vfront_len;
    } timing_cfg_t;

    typedef struct packed {
        logic              hsync_level;
        logic              vsync_level;
        logic [SAMP_W-1:0] red_in;
        logic [SAMP_W-1:0] green_in;
        logic [SAMP_W-1:0] blue_in;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  pixel_x;
        logic [POS_W-1:0]  pixel_y;
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } out_item_t;

    // Result handed from the tracker to the output buffer
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

    // Tracker status, watched at the top level
    typedef struct packed {
        logic [CNT_W-1:0] column;
        logic [CNT_W-1:0] line;
        logic             sync_err;
    } track_status_t;

    // Keep the low bits of the sample, then floor(s * 255 / 2^bits)
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [SAMP_W-1:0] v,
                                                     input int unsigned bits);
        logic [CHAN_W-1:0]   mask;
        logic [CHAN_W-1:0]   s;
        logic [2*CHAN_W-1:0] prod;
        mask = CHAN_W'((9'd1 << bits) - 9'd1);
        s    = {{(CHAN_W-SAMP_W){1'b0}}, v} & mask;
        prod = {{CHAN_W{1'b0}}, s} * 16'd255;
        return CHAN_W'(prod >> bits);
    endfunction

endpackage

FILE: sv/vga_sync_checking_pixel_capture_top.sv
// ============================================================================
// vga_sync_checking_pixel_capture_top - sync-checking video pixel capture
// Tracks position from hsync/vsync, relocks on any sync mismatch and emits
// the active-window pixels with each color channel scaled to 8 bits.
// ============================================================================
//
//  channel | signals                                | direction | handshake
//  --------+----------------------------------------+-----------+-----------
//  input   | in_valid, in_ready, in_item            | in        | valid/ready
//  output  | out_valid, out_ready, out_item         | out       | valid/ready
//  config  | cfg_we, cfg_index, cfg_data            | in        | write enable
//
//  One item per cycle while in_ready is high: the sync check, capture and
//  counter advance for an item happen in the cycle it is accepted, and its
//  result is registered in the output or skid register. The 12-bit counter
//  increment and compare against the line total set the cycle time.
//  rst_n clears the counters and the output buffer, and loads the default
//  640x480 timing. A stalled consumer fills the output register and then
//  the skid stage; in_ready drops only once both hold a result.
//
module vga_sync_checking_pixel_capture_top
    import vsc_pkg::*;
#(
    parameter int RED_BITS   = DEF_RED_BITS,
    parameter int GREEN_BITS = DEF_GREEN_BITS,
    parameter int BLUE_BITS  = DEF_BLUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,

    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    timing_cfg_t   cfg_reg, cfg_next;
    result_t       result;
    track_status_t status;
    logic          space;
    logic          in_fire;

    // ------------------------------------------------------------------
    // Timing registers: load one register per write, no read-back
    // ------------------------------------------------------------------
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HSYNC_LEN:   cfg_next.hsync_len   = cfg_data[LEN8_W-1:0];
                CFG_HBACK_LEN:   cfg_next.hback_len   = cfg_data[LEN8_W-1:0];
                CFG_HACTIVE_LEN: cfg_next.hactive_len = cfg_data[LEN11_W-1:0];
                CFG_HFRONT_LEN:  cfg_next.hfront_len  = cfg_data[LEN8_W-1:0];
                CFG_VSYNC_LEN:   cfg_next.vsync_len   = cfg_data[LEN8_W-1:0];
                CFG_VBACK_LEN:   cfg_next.vback_len   = cfg_data[LEN8_W-1:0];
                CFG_VACTIVE_LEN: cfg_next.vactive_len = cfg_data[LEN11_W-1:0];
                CFG_VFRONT_LEN:  cfg_next.vfront_len  = cfg_data[LEN8_W-1:0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hsync_len   <= RST_HSYNC_LEN;
            cfg_reg.hback_len   <= RST_HBACK_LEN;
            cfg_reg.hactive_len <= RST_HACTIVE_LEN;
            cfg_reg.hfront_len  <= RST_HFRONT_LEN;
            cfg_reg.vsync_len   <= RST_VSYNC_LEN;
            cfg_reg.vback_len   <= RST_VBACK_LEN;
            cfg_reg.vactive_len <= RST_VACTIVE_LEN;
            cfg_reg.vfront_len  <= RST_VFRONT_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Accept an item whenever the skid stage is free
    // ------------------------------------------------------------------
    assign in_ready = space;
    assign in_fire  = in_valid && in_ready;

    // Check sync, capture the pixel and advance the counters
    vsc_tracker #(
        .RED_BITS   (RED_BITS),
        .GREEN_BITS (GREEN_BITS),
        .BLUE_BITS  (BLUE_BITS)
    ) u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_fire),
        .item   (in_item),
        .cfg    (cfg_reg),
        .result (result),
        .status (status)
    );

    // Hold results until the consumer takes them
    vsc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A sync mismatch relocks both counters to the frame start
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && status.sync_err |=> (status.column == '0) && (status.line == '0))
        else $error("counters not cleared after sync mismatch");

    // No result comes from an item that failed the sync check
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> in_fire && !status.sync_err)
        else $error("result produced without a clean accepted item");

    // Counters move only on an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(status.column) && $stable(status.line))
        else $error("counters moved without an accepted item");

    // Input side stalls only when a result is already waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with an empty output register");

endmodule

FILE: sv/vsc_tracker.sv
// ============================================================================
// vsc_tracker - position counters, sync check and pixel capture
// Checks sync against the counters, forms the result, advances the counters.
// ============================================================================
module vsc_tracker
    import vsc_pkg::*;
#(
    parameter int RED_BITS   = DEF_RED_BITS,
    parameter int GREEN_BITS = DEF_GREEN_BITS,
    parameter int BLUE_BITS  = DEF_BLUE_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  in_item_t      item,
    input  timing_cfg_t   cfg,
    output result_t       result,
    output track_status_t status
);

    logic [CNT_W-1:0] column_reg, column_next;
    logic [CNT_W-1:0] line_reg, line_next;

    logic [CNT_W-1:0] hs_end, hd_start, hd_end, h_total;
    logic [CNT_W-1:0] vs_end, vd_start, vd_end, v_total;
    logic [CNT_W-1:0] col_inc, col_wrap, line_inc, line_wrap;
    logic             h_bad, v_bad, sync_err, in_window;

    // Region limits from the timing registers; all sums stay within 12 bits
    assign hs_end   = {{(CNT_W-LEN8_W){1'b0}}, cfg.hsync_len};
    assign hd_start = hs_end + {{(CNT_W-LEN8_W){1'b0}}, cfg.hback_len};
    assign hd_end   = hd_start + {{(CNT_W-LEN11_W){1'b0}}, cfg.hactive_len};
    assign h_total  = hd_end + {{(CNT_W-LEN8_W){1'b0}}, cfg.hfront_len};
    assign vs_end   = {{(CNT_W-LEN8_W){1'b0}}, cfg.vsync_len};
    assign vd_start = vs_end + {{(CNT_W-LEN8_W){1'b0}}, cfg.vback_len};
    assign vd_end   = vd_start + {{(CNT_W-LEN11_W){1'b0}}, cfg.vactive_len};
    assign v_total  = vd_end + {{(CNT_W-LEN8_W){1'b0}}, cfg.vfront_len};

    // Sync must be low inside the sync region and high past it
    assign h_bad    = (column_reg < hs_end) ? item.hsync_level : !item.hsync_level;
    assign v_bad    = (line_reg < vs_end) ? item.vsync_level : !item.vsync_level;
    assign sync_err = h_bad || v_bad;

    assign in_window = (column_reg >= hd_start) && (column_reg < hd_end) &&
                       (line_reg >= vd_start) && (line_reg < vd_end);

    assign col_inc   = column_reg + 12'd1;
    assign col_wrap  = (col_inc == h_total) ? '0 : col_inc;
    assign line_inc  = (col_wrap == '0) ? (line_reg + 12'd1) : line_reg;
    assign line_wrap = (line_inc == v_total) ? '0 : line_inc;

    always_comb
    begin
        column_next = column_reg;
        line_next   = line_reg;
        if (step)
        begin
            if (sync_err)
            begin
                column_next = '0;
                line_next   = '0;
            end
            else
            begin
                column_next = col_wrap;
                line_next   = line_wrap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            line_reg   <= '0;
        end
        else
        begin
            column_reg <= column_next;
            line_reg   <= line_next;
        end
    end

    logic [CNT_W-1:0] x_full, y_full;
    assign x_full = column_reg - hd_start;
    assign y_full = line_reg - vd_start;

    assign result.valid          = step && !sync_err && in_window;
    assign result.item.pixel_x   = x_full[POS_W-1:0];
    assign result.item.pixel_y   = y_full[POS_W-1:0];
    assign result.item.red_out   = scale_chan(item.red_in, RED_BITS);
    assign result.item.green_out = scale_chan(item.green_in, GREEN_BITS);
    assign result.item.blue_out  = scale_chan(item.blue_in, BLUE_BITS);

    assign status.column   = column_reg;
    assign status.line     = line_reg;
    assign status.sync_err = sync_err;

endmodule

FILE: sv/vsc_out_buf.sv
// ============================================================================
// vsc_out_buf - result register with a skid stage
// Holds results while the consumer stalls; input side stops when both fill.
// ============================================================================
module vsc_out_buf
    import vsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  result_t   result,
    output logic      space,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t main_reg, main_next;
    out_item_t skid_reg, skid_next;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                // drain the skid stage first; no push arrives while it is full
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = result.item;
                main_valid_next = result.valid;
            end
        end
        else if (result.valid)
        begin
            skid_next       = result.item;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;

endmodule
